// ===== hw/rtl/mf3_pkg.sv =====
// Shared constants for the 3x3 median filter: field widths, defaults and
// configuration register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mf3_pkg;

  localparam int unsigned DEF_MAX_LINE_WIDTH = 1024;
  localparam int unsigned DEF_PIXEL_BITS     = 8;

  localparam int unsigned ROW_W      = 16;
  localparam int unsigned IMG_W_BITS = 11;
  localparam int unsigned IMG_H_BITS = 16;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = 11'd640;
  localparam logic [IMG_H_BITS-1:0] IMG_H_RESET = 16'd480;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } mf3_reg_e;

endpackage

`default_nettype wire

// ===== hw/rtl/mf3_line_buf.sv =====
// Dual line buffer memory: one write and one registered read per cycle.
// Standalone; instantiated by median_filter_3x3_top.
`timescale 1ns / 1ps
`default_nettype none

module mf3_line_buf #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned DATA_W = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [DATA_W-1:0]        rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0]        wr_data_i
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read-before-write on a collision; the caller forwards
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mf3_median9.sv =====
// Median of nine pixels through the 19 compare-and-swap network.
// Pure combinational; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module mf3_median9 #(
  parameter int unsigned PIX_W = 8
) (
  input  wire logic [8:0][PIX_W-1:0] win_i,
  output logic      [PIX_W-1:0]      median_o
);

  // returns {max, min}
  function automatic logic [2*PIX_W-1:0] sort2(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    sort2 = (a > b) ? {a, b} : {b, a};
  endfunction

  logic [8:0][PIX_W-1:0] v;

  always_comb begin
    v = win_i;
    // rows sorted
    {v[2], v[1]} = sort2(v[1], v[2]);
    {v[5], v[4]} = sort2(v[4], v[5]);
    {v[8], v[7]} = sort2(v[7], v[8]);
    {v[1], v[0]} = sort2(v[0], v[1]);
    {v[4], v[3]} = sort2(v[3], v[4]);
    {v[7], v[6]} = sort2(v[6], v[7]);
    {v[2], v[1]} = sort2(v[1], v[2]);
    {v[5], v[4]} = sort2(v[4], v[5]);
    {v[8], v[7]} = sort2(v[7], v[8]);
    // merge columns toward the center
    {v[3], v[0]} = sort2(v[0], v[3]);
    {v[8], v[5]} = sort2(v[5], v[8]);
    {v[7], v[4]} = sort2(v[4], v[7]);
    {v[6], v[3]} = sort2(v[3], v[6]);
    {v[4], v[1]} = sort2(v[1], v[4]);
    {v[5], v[2]} = sort2(v[2], v[5]);
    {v[7], v[4]} = sort2(v[4], v[7]);
    {v[2], v[4]} = sort2(v[4], v[2]);
    {v[4], v[6]} = sort2(v[6], v[4]);
    {v[2], v[4]} = sort2(v[4], v[2]);
  end

  assign median_o = v[4];

endmodule

`default_nettype wire

// ===== hw/rtl/median_filter_3x3_top.sv =====
// 3x3 median filter over a raster-order pixel stream. An input word is
// accepted every cycle that the output side is not stalled; its result
// (interior positions only) is loaded into the output register at the
// clock edge after acceptance, later only while a held result blocks the
// pipeline. The single-port-read / single-port-write line buffer and the
// window registers allow one pixel per clock; a read of the entry that is
// written in the same cycle (frame restart at column 0) is forwarded.
// Line buffers need no clearing after reset. tlast marks the last
// interior pixel of a frame; tuser on the input marks the first pixel.
// Depends on mf3_pkg, mf3_line_buf, mf3_median9.
`timescale 1ns / 1ps
`default_nettype none

module median_filter_3x3_top
  import mf3_pkg::*;
#(
  parameter int unsigned MAX_LINE_WIDTH = DEF_MAX_LINE_WIDTH,
  parameter int unsigned PIXEL_BITS     = DEF_PIXEL_BITS,
  localparam int unsigned COL_W      = $clog2(MAX_LINE_WIDTH),
  localparam int unsigned IN_TDATA_W = ((PIXEL_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_TDATA_W = ((PIXEL_BITS + COL_W + ROW_W + 7) / 8) * 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  // pixel input
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // pixel
  input  wire logic                   s_axis_tuser,   // frame_start
  // filtered output
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // median, out_col, out_row
  output logic                        m_axis_tlast    // frame_end
);

  localparam int unsigned CNT_W = $clog2(MAX_LINE_WIDTH + 1);

  // ---------------- configuration ----------------
  logic [IMG_W_BITS-1:0] image_width_q;
  logic [IMG_H_BITS-1:0] image_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= IMG_W_RESET;
      image_height_q <= IMG_H_RESET;
    end else if (cfg_we_i) begin
      unique case (mf3_reg_e'(cfg_addr_i))
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[IMG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] wid_eff;
  logic [CNT_W-1:0] wid_m1;
  logic [ROW_W-1:0] hgt_eff;
  logic [ROW_W-1:0] hgt_m1;

  always_comb begin
    if (image_width_q < IMG_W_BITS'(3)) begin
      wid_eff = CNT_W'(3);
    end else if (32'(image_width_q) > 32'(MAX_LINE_WIDTH)) begin
      wid_eff = CNT_W'(MAX_LINE_WIDTH);
    end else begin
      wid_eff = CNT_W'(image_width_q);
    end
    hgt_eff = (image_height_q < 16'd3) ? 16'd3 : image_height_q;
    wid_m1  = wid_eff - CNT_W'(1);
    hgt_m1  = hgt_eff - 16'd1;
  end

  // ---------------- flow control ----------------
  logic en;
  logic out_valid_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- stage 0: position counters ----------------
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] c0, x0;
  logic [ROW_W-1:0] r0, y0;
  logic [CNT_W-1:0] nxt0;
  logic             emit0, last0;
  logic [PIXEL_BITS-1:0] pix0;

  assign pix0 = s_axis_tdata[PIXEL_BITS-1:0];

  always_comb begin
    c0 = s_axis_tuser ? '0 : col_q;
    r0 = s_axis_tuser ? '0 : row_q;
    // column left over from a wider line wraps first
    if (CNT_W'(c0) >= wid_eff) begin
      x0 = '0;
      y0 = r0 + 16'd1;
    end else begin
      x0 = c0;
      y0 = r0;
    end
    nxt0 = CNT_W'(x0) + CNT_W'(1);
    if (nxt0 >= wid_eff) begin
      col_d = '0;
      row_d = y0 + 16'd1;
    end else begin
      col_d = COL_W'(nxt0);
      row_d = y0;
    end
    emit0 = (x0 >= COL_W'(2)) && (y0 >= 16'd2) && (y0 < hgt_eff);
    last0 = (CNT_W'(x0) == wid_m1) && (y0 == hgt_m1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (en && s_axis_tvalid) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------- stage 1: line buffer read, window, median ----------------
  logic                  s1_valid_q;
  logic                  s1_emit_q;
  logic                  s1_last_q;
  logic [COL_W-1:0]      s1_x_q;
  logic [COL_W-1:0]      s1_col_q;
  logic [ROW_W-1:0]      s1_row_q;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic                  fwd_q;
  logic [PIXEL_BITS-1:0] fwd_top_q, fwd_mid_q;
  logic [2*PIXEL_BITS-1:0] rd_data;
  logic [PIXEL_BITS-1:0] top1, mid1;
  logic [5:0][PIXEL_BITS-1:0] win_q;
  logic [8:0][PIXEL_BITS-1:0] win9;
  logic [PIXEL_BITS-1:0] median1;

  // entry layout: {line two above, line above}
  mf3_line_buf #(
    .DEPTH  (MAX_LINE_WIDTH),
    .DATA_W (2 * PIXEL_BITS)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (en),
    .rd_addr_i (x0),
    .rd_data_o (rd_data),
    .wr_en_i   (en && s1_valid_q),
    .wr_addr_i (s1_x_q),
    .wr_data_i ({mid1, s1_pix_q})
  );

  assign top1 = fwd_q ? fwd_top_q : rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
  assign mid1 = fwd_q ? fwd_mid_q : rd_data[PIXEL_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid;
      fwd_q      <= s1_valid_q && (x0 == s1_x_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_emit_q <= emit0;
      s1_last_q <= last0;
      s1_x_q    <= x0;
      s1_col_q  <= x0 - COL_W'(1);
      s1_row_q  <= y0 - 16'd1;
      s1_pix_q  <= pix0;
      fwd_top_q <= mid1;
      fwd_mid_q <= s1_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (en && s1_valid_q) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top1;
      win_q[4] <= mid1;
      win_q[5] <= s1_pix_q;
    end
  end

  assign win9 = {s1_pix_q, win_q[5], win_q[2], mid1, win_q[4], win_q[1],
                 top1, win_q[3], win_q[0]};

  mf3_median9 #(
    .PIX_W (PIXEL_BITS)
  ) u_median9 (
    .win_i    (win9),
    .median_o (median1)
  );

  // ---------------- output register ----------------
  logic [PIXEL_BITS-1:0] median_q;
  logic [COL_W-1:0]      out_col_q;
  logic [ROW_W-1:0]      out_row_q;
  logic                  frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      median_q    <= median1;
      out_col_q   <= s1_col_q;
      out_row_q   <= s1_row_q;
      frame_end_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_row_q, out_col_q, median_q});
  assign m_axis_tlast  = frame_end_q;

  // ---------------- assertions ----------------
  a_interior_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_col_q != '0) && (out_row_q != '0))
    else $error("result for a border position");

  a_emit_reaches_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && s1_valid_q && s1_emit_q |=> out_valid_q)
    else $error("interior word lost between window and output");

  a_forward_on_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && s_axis_tvalid && s1_valid_q && (x0 == s1_x_q) |=> fwd_q)
    else $error("line buffer collision not forwarded");

endmodule

`default_nettype wire

// ===== verif/tb_median_filter_3x3_top.sv =====
// Self-checking testbench for median_filter_3x3_top: directed and random
// pixel frames against an in-bench predictor of the 3x3 median filter.
// Depends on mf3_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_median_filter_3x3_top;
  import mf3_pkg::*;

  localparam int unsigned COL_BITS    = $clog2(DEF_MAX_LINE_WIDTH);
  localparam int unsigned IN_TDATA_W  = ((DEF_PIXEL_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((DEF_PIXEL_BITS + COL_BITS + ROW_W + 7) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned TAIL_CYCLES = 8;

  // compare-and-swap pairs of the median network, first pair in the top byte
  localparam bit [151:0] SORT_NET = {
    8'h12, 8'h45, 8'h78, 8'h01, 8'h34, 8'h67, 8'h12, 8'h45, 8'h78, 8'h03,
    8'h58, 8'h47, 8'h36, 8'h14, 8'h25, 8'h47, 8'h42, 8'h64, 8'h42
  };

  typedef struct packed {
    logic [7:0] pixel;
    logic       first;
  } pixel_word_t;

  typedef struct packed {
    logic [7:0]          median;
    logic [COL_BITS-1:0] col;
    logic [ROW_W-1:0]    row;
    logic                frame_end;
  } median_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we = 1'b0;
  mf3_reg_e              cfg_addr = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  wire logic              s_tready;
  wire logic              m_tvalid;
  logic                   m_tready = 1'b0;
  wire logic [OUT_TDATA_W-1:0] m_tdata;
  wire logic              m_tlast;

  median_filter_3x3_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tlast (m_tlast)
  );

  pixel_word_t    pixel_q[$];
  median_result_t median_q[$];
  int unsigned    err_count = 0;
  int unsigned    pushed = 0;
  int unsigned    cycle_count = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;

  // predictor state
  logic [IMG_W_BITS-1:0] cfg_width = IMG_W_RESET;
  logic [IMG_H_BITS-1:0] cfg_height = IMG_H_RESET;
  logic [7:0]            prev_line[DEF_MAX_LINE_WIDTH];
  logic [7:0]            prev2_line[DEF_MAX_LINE_WIDTH];
  logic [7:0]            win[6] = '{default: 8'd0};
  int unsigned           col_cnt = 0;
  logic [ROW_W-1:0]      row_cnt = '0;

  function automatic int unsigned eff_width(input logic [IMG_W_BITS-1:0] w);
    if (w < 3) return 3;
    if (w > DEF_MAX_LINE_WIDTH) return DEF_MAX_LINE_WIDTH;
    return 32'(w);
  endfunction

  function automatic int unsigned eff_height(input logic [IMG_H_BITS-1:0] h);
    return (h < 3) ? 3 : 32'(h);
  endfunction

  function automatic void predict_median(input logic [7:0] pix, input logic first);
    int unsigned    wid, hgt, x, ia, ib;
    logic [ROW_W-1:0] y;
    logic [7:0]     top, mid, tmp;
    logic [7:0]     v[9];
    median_result_t r;
    wid = eff_width(cfg_width);
    hgt = eff_height(cfg_height);
    if (first) begin
      col_cnt = 0;
      row_cnt = '0;
    end
    if (col_cnt >= wid) begin
      col_cnt = 0;
      row_cnt = row_cnt + 1'b1;
    end
    x = col_cnt;
    y = row_cnt;
    top = prev2_line[x];
    mid = prev_line[x];
    if (x >= 2 && y >= 2 && y < hgt) begin
      v[0] = win[0]; v[1] = win[3]; v[2] = top;
      v[3] = win[1]; v[4] = win[4]; v[5] = mid;
      v[6] = win[2]; v[7] = win[5]; v[8] = pix;
      for (int k = 0; k < 19; k++) begin
        ia = 32'(SORT_NET[(18 - k) * 8 + 4 +: 4]);
        ib = 32'(SORT_NET[(18 - k) * 8 +: 4]);
        if (v[ia] > v[ib]) begin
          tmp = v[ia];
          v[ia] = v[ib];
          v[ib] = tmp;
        end
      end
      r.median    = v[4];
      r.col       = COL_BITS'(x - 1);
      r.row       = y - 1'b1;
      r.frame_end = (x == wid - 1) && (y == hgt - 1);
      median_q.push_back(r);
    end
    prev2_line[x] = mid;
    prev_line[x]  = pix;
    win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
    win[3] = top;    win[4] = mid;    win[5] = pix;
    col_cnt = x + 1;
    if (col_cnt >= wid) begin
      col_cnt = 0;
      row_cnt = row_cnt + 1'b1;
    end
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // input driver: one word per handshake from pixel_q
  always @(posedge clk_i) begin
    pixel_word_t w;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_median(s_tdata[7:0], s_tuser);
      if (!s_tvalid || s_tready) begin
        if (pixel_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          w = pixel_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= IN_TDATA_W'(w.pixel);
          s_tuser  <= w.first;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor and back-pressure
  always @(posedge clk_i) begin
    median_result_t e;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (median_q.size() == 0) begin
          $error("unexpected result word: tdata=%h tlast=%b", m_tdata, m_tlast);
          err_count++;
        end else begin
          e = median_q.pop_front();
          if (m_tdata[7:0] !== e.median) begin
            $error("median: expected %0d, got %0d", e.median, m_tdata[7:0]);
            err_count++;
          end
          if (m_tdata[8 +: COL_BITS] !== e.col) begin
            $error("out_col: expected %0d, got %0d", e.col, m_tdata[8 +: COL_BITS]);
            err_count++;
          end
          if (m_tdata[8 + COL_BITS +: ROW_W] !== e.row) begin
            $error("out_row: expected %0d, got %0d", e.row, m_tdata[8 + COL_BITS +: ROW_W]);
            err_count++;
          end
          if (m_tlast !== e.frame_end) begin
            $error("frame_end: expected %0d, got %0d", e.frame_end, m_tlast);
            err_count++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic push_pixel(input logic [7:0] pix, input logic first);
    pixel_word_t w;
    w.pixel = pix;
    w.first = first;
    pixel_q.push_back(w);
    pushed++;
  endtask

  // everything sent and every result seen, then a settle wait
  task automatic wait_quiet();
    while (pixel_q.size() > 0 || s_tvalid || median_q.size() > 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(input mf3_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    if (idx == REG_IMAGE_WIDTH) cfg_width = value[IMG_W_BITS-1:0];
    else cfg_height = value[IMG_H_BITS-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(input logic [15:0] w, input logic [15:0] h);
    wait_quiet();
    cfg_write(REG_IMAGE_WIDTH, w);
    cfg_write(REG_IMAGE_HEIGHT, h);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_pixel(input int style, input logic [7:0] base);
    case (style)
      0: return 8'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return base ^ 8'($urandom_range(0, 3));
    endcase
  endfunction

  // well-formed frame, optionally trailed by rows past the frame bottom
  task automatic send_frame(input int unsigned w, input int unsigned h,
                            input int unsigned extra_rows);
    int         style;
    logic [7:0] base;
    style = $urandom_range(0, 3);
    base  = 8'($urandom_range(0, 255));
    for (int unsigned i = 0; i < w * (h + extra_rows); i++)
      push_pixel(pick_pixel(style, base), i == 0);
  endtask

  // broken sequence: random length, stray frame starts
  task automatic send_noise(input int unsigned w, input int unsigned h);
    int unsigned n;
    n = $urandom_range(1, w * h + w);
    for (int unsigned i = 0; i < n; i++)
      push_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 3);
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned start, sel, frames;
    logic [15:0] w_raw, h_raw;
    start = pushed;
    while (pushed - start < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) w_raw = 16'($urandom_range(3, 12));
      else if (sel < 80) w_raw = 16'($urandom_range(0, 2));
      else if (sel < 90) w_raw = 16'($urandom_range(13, 40));
      else w_raw = 16'(($urandom_range(1, 31) << 11) | $urandom_range(3, 10));
      sel = $urandom_range(0, 99);
      if (sel < 60) h_raw = 16'($urandom_range(3, 8));
      else if (sel < 75) h_raw = 16'($urandom_range(0, 2));
      else h_raw = 16'($urandom_range(9, 14));
      set_geometry(w_raw, h_raw);
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        // first frame after a geometry change always opens with a frame start
        if (f == 0 || $urandom_range(0, 99) < 80)
          send_frame(eff_width(w_raw[IMG_W_BITS-1:0]), eff_height(h_raw),
                     ($urandom_range(0, 99) < 30) ? $urandom_range(1, 2) : 0);
        else
          send_noise(eff_width(w_raw[IMG_W_BITS-1:0]), eff_height(h_raw));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 19;
    recv_idle_pct = 78;

    // smallest frame: pixel extremes, then hold off until drained
    set_geometry(16'd3, 16'd3);
    for (int i = 0; i < 9; i++) push_pixel((i % 2 == 0) ? 8'hFF : 8'h00, i == 0);
    wait_quiet();
    // no frame start: one row below the frame, no result expected
    for (int i = 0; i < 3; i++) push_pixel(8'($urandom_range(0, 255)), 1'b0);
    // descending values, all distinct
    for (int i = 0; i < 9; i++) push_pixel(8'(200 - 20 * i), i == 0);
    // restart inside a frame
    push_pixel(8'h80, 1'b1);
    push_pixel(8'h7F, 1'b0);
    push_pixel(8'h01, 1'b1);

    run_random(120);

    send_idle_pct = 78;
    recv_idle_pct = 19;
    // width above the line buffer depth clamps to it: two full lines and
    // three pixels reach the first interior position
    set_geometry(16'hFFFF, 16'd3);
    for (int i = 0; i < 2 * DEF_MAX_LINE_WIDTH + 3; i++)
      push_pixel(8'($urandom_range(0, 255)), i == 0);
    // tallest frame, only the top rows
    set_geometry(16'd5, 16'hFFFF);
    for (int i = 0; i < 30; i++) push_pixel(8'($urandom_range(0, 255)), i == 0);
    run_random(120);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(120);

    wait_quiet();
    if (median_q.size() != 0) begin
      $error("%0d expected results never arrived", median_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mf3_pkg.sv
hw/rtl/mf3_line_buf.sv
hw/rtl/mf3_median9.sv
hw/rtl/median_filter_3x3_top.sv
verif/tb_median_filter_3x3_top.sv
